// ===== rtl/core/gsbs_pkg.sv =====
// Shared types and constants for the grid store with bilinear sampler.
// Holds grid geometry, op codes, sequencer states and channel word types.
// No dependencies.
package gsbs_pkg;

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam int DEPTH  = GRID_W * GRID_H;
    localparam int XW     = $clog2(GRID_W);
    localparam int ZW     = $clog2(GRID_H);
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [3:0] OP_READ_IDX   = 4'd0;
    localparam logic [3:0] OP_WRITE_IDX  = 4'd1;
    localparam logic [3:0] OP_ADD_IDX    = 4'd2;
    localparam logic [3:0] OP_READ_COORD = 4'd3;
    localparam logic [3:0] OP_WRITE_COORD= 4'd4;
    localparam logic [3:0] OP_SAMPLE     = 4'd5;
    localparam logic [3:0] OP_MAX        = 4'd6;
    localparam logic [3:0] OP_MIN        = 4'd7;
    localparam logic [3:0] OP_MAXABS     = 4'd8;
    localparam logic [3:0] OP_FILL       = 4'd9;
    localparam logic [3:0] OP_SCALE      = 4'd10;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd1;
    localparam logic [2:0] REG_INV_X    = 3'd2;
    localparam logic [2:0] REG_INV_Z    = 3'd3;
    localparam logic [2:0] REG_OOB      = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_IDX, ST_IDXD,
        ST_MXL, ST_MXH, ST_MZL, ST_MZH, ST_MZF,
        ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8,
        ST_SCAN, ST_SCANE, ST_FILL,
        ST_SC0, ST_SC1, ST_SC2, ST_SC3,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [15:0] x_index;
        logic signed [15:0] z_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_z;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               ok;
        logic [5:0]         found_x;
        logic [5:0]         found_z;
    } out_word_t;

endpackage

// ===== rtl/core/gsbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/grid_store_bilinear_sampler.sv =====
// Grid store with bilinear sampler: sequencer, shared multiplier and config port.
// Depends on gsbs_pkg and gsbs_ram.
//
// Usage: one input word (op and operands) is taken on in_valid while in_stall is
// low; each word yields exactly one result word on out_valid/out_stall. The
// block takes one word at a time; in_stall stays high while a word is at work.
// Steps per op, as the sequencer runs them: read/write by coordinate first
// form two 33x17 partial products per axis through the one shared multiplier,
// then access the cell as read/write by index do; sample: four grid reads over
// the single read port, then three lerps on the shared multiplier;
// max/min/maxabs: one cell per cycle; fill: one write per cell;
// scale: read, two partial products, write per cell.
// A finished result sits in the output register; if the receiver stalls it is
// held there unchanged, and the next word may be taken and worked on until it
// too must hand over its result. Reset clears the sequencer, the output valid
// and the configuration registers to their defaults; grid contents are undefined
// until written or filled. Configuration goes over the APB-style port (pready
// always high); the user must write it only while idle; the block does not check.
module grid_store_bilinear_sampler
    import gsbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic signed [31:0] origin_x_reg, origin_z_reg, oob_reg;
    logic [30:0]        inv_x_reg, inv_z_reg;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_z_reg <= '0;
            inv_x_reg    <= 31'd65536;
            inv_z_reg    <= 31'd65536;
            oob_reg      <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_ORIGIN_X: origin_x_reg <= pwdata;
                REG_ORIGIN_Z: origin_z_reg <= pwdata;
                REG_INV_X:    inv_x_reg    <= pwdata[30:0];
                REG_INV_Z:    inv_z_reg    <= pwdata[30:0];
                REG_OOB:      oob_reg      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ORIGIN_X: prdata = origin_x_reg;
            REG_ORIGIN_Z: prdata = origin_z_reg;
            REG_INV_X:    prdata = {1'b0, inv_x_reg};
            REG_INV_Z:    prdata = {1'b0, inv_z_reg};
            REG_OOB:      prdata = oob_reg;
            default:      prdata = '0;
        endcase
    end

    // grid memory
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]       ram_wdata, ram_rdata;

    gsbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic in_grid(logic signed [32:0] x, logic signed [32:0] z);
        return (x >= 0) && (x < 33'sd0 + 33'(GRID_W)) && (z >= 0) && (z < 33'(GRID_H));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [XW-1:0] x, logic [ZW-1:0] z);
        return ADDR_W'(x) + ADDR_W'(z) * ADDR_W'(GRID_W);
    endfunction

    // round-half-up of (a*2^16 + p) / 2^16
    function automatic logic signed [31:0] lerp_fin(logic signed [31:0] a,
                                                     logic signed [49:0] p);
        logic signed [50:0] s;
        s = 51'(a) * 51'sd65536 + 51'(p) + 51'sd32768;
        return s[47:16];
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // sequencer state and datapath registers
    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    in_word_t           item_reg, item_next;
    logic signed [31:0] res_reg, res_next;
    logic               ok_reg, ok_next;
    logic [5:0]         fx_reg, fx_next, fz_reg, fz_next;
    out_word_t          out_reg, out_next;
    logic signed [32:0] cx_reg, cx_next, cz_reg, cz_next;
    logic [15:0]        tx_reg, tx_next, tz_reg, tz_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [49:0] prod_reg;
    logic signed [31:0] c_reg, c_next, d_reg, d_next, a_reg, a_next, b_reg, b_next;
    logic signed [31:0] l1_reg, l1_next, l2_reg, l2_next, cell_reg, cell_next;
    logic               prev_in_reg, prev_in_next, pv_reg, pv_next, first_reg, first_next;
    logic [XW-1:0]      sx_reg, sx_next, dx_reg, dx_next;
    logic [ZW-1:0]      sz_reg, sz_next, dz_reg, dz_next;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;

    logic               accept, slot_free, last_cell, ing, is_max, is_min;
    logic signed [32:0] dcx, dcz, corner_x, corner_z;
    logic signed [63:0] pos_v, bias;
    logic signed [31:0] corner_v, scan_v;
    logic signed [65:0] scale_v;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign last_cell = (sx_reg == XW'(GRID_W - 1)) && (sz_reg == ZW'(GRID_H - 1));
    assign dcx       = 33'(item_reg.coord_x) - 33'(origin_x_reg);
    assign dcz       = 33'(item_reg.coord_z) - 33'(origin_z_reg);
    assign bias      = (item_reg.op == OP_SAMPLE) ? 64'sh80000000 : 64'sd0;
    assign pos_v     = acc_reg + 64'(prod_reg) * 64'sd65536;
    assign corner_v  = prev_in_reg ? ram_rdata : oob_reg;
    assign scale_v   = (66'(acc_reg) + 66'(prod_reg) * 66'sd65536 + 66'sd32768) >>> 16;
    assign is_max    = (item_reg.op == OP_MAX) || (item_reg.op == OP_MAXABS);
    assign is_min    = (item_reg.op == OP_MIN);

    always_comb
    begin
        if (item_reg.op == OP_MAXABS && ram_rdata[31])
        begin
            scan_v = (ram_rdata == 32'sh80000000) ? 32'sh7FFFFFFF : -ram_rdata;
        end
        else
        begin
            scan_v = ram_rdata;
        end
    end

    always_comb
    begin
        corner_x = cx_reg;
        corner_z = cz_reg;
        if (state_reg == ST_S1 || state_reg == ST_S3)
        begin
            corner_x = cx_reg + 33'sd1;
        end
        if (state_reg == ST_S2 || state_reg == ST_S3)
        begin
            corner_z = cz_reg + 33'sd1;
        end
        ing = in_grid(corner_x, corner_z);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MXL: begin mul_a = dcx; mul_b = {1'b0, inv_x_reg[15:0]}; end
            ST_MXH: begin mul_a = dcx; mul_b = {2'b0, inv_x_reg[30:16]}; end
            ST_MZL: begin mul_a = dcz; mul_b = {1'b0, inv_z_reg[15:0]}; end
            ST_MZH: begin mul_a = dcz; mul_b = {2'b0, inv_z_reg[30:16]}; end
            ST_S4:  begin mul_a = 33'(d_reg) - 33'(c_reg); mul_b = {1'b0, tx_reg}; end
            ST_S5:  begin mul_a = 33'(b_reg) - 33'(a_reg); mul_b = {1'b0, tx_reg}; end
            ST_S7:  begin mul_a = 33'(l2_reg) - 33'(l1_reg); mul_b = {1'b0, tz_reg}; end
            ST_SC1: begin mul_a = 33'($signed(ram_rdata));
                          mul_b = {1'b0, item_reg.value[15:0]}; end
            ST_SC2: begin mul_a = 33'(cell_reg);
                          mul_b = 17'($signed(item_reg.value[31:16])); end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 50'(mul_a * mul_b);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        ok_next        = ok_reg;
        fx_next        = fx_reg;
        fz_next        = fz_reg;
        cx_next        = cx_reg;
        cz_next        = cz_reg;
        tx_next        = tx_reg;
        tz_next        = tz_reg;
        acc_next       = acc_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        l1_next        = l1_reg;
        l2_next        = l2_reg;
        cell_next      = cell_reg;
        prev_in_next   = prev_in_reg;
        pv_next        = 1'b0;
        first_next     = first_reg;
        sx_next        = sx_reg;
        sz_next        = sz_reg;
        dx_next        = dx_reg;
        dz_next        = dz_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = cell_addr(cx_reg[XW-1:0], cz_reg[ZW-1:0]);
        ram_raddr      = cell_addr(corner_x[XW-1:0], corner_z[ZW-1:0]);
        ram_wdata      = item_reg.value;

        // running best for the scans
        if (pv_reg && (first_reg || (is_min ? scan_v < res_reg : scan_v > res_reg)))
        begin
            res_next   = scan_v;
            fx_next    = 6'(dx_reg);
            fz_next    = 6'(dz_reg);
            first_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_word;
                    res_next  = '0;
                    ok_next   = 1'b0;
                    fx_next   = '0;
                    fz_next   = '0;
                    cx_next   = 33'(in_word.x_index);
                    cz_next   = 33'(in_word.z_index);
                    sx_next   = '0;
                    sz_next   = '0;
                    first_next = 1'b1;
                    priority if (in_word.op <= OP_ADD_IDX)      state_next = ST_IDX;
                    else if (in_word.op <= OP_SAMPLE)           state_next = ST_MXL;
                    else if (in_word.op <= OP_MAXABS)           state_next = ST_SCAN;
                    else if (in_word.op == OP_FILL)             state_next = ST_FILL;
                    else if (in_word.op == OP_SCALE)            state_next = ST_SC0;
                    else                                        state_next = ST_DONE;
                end
            end
            ST_MXL: state_next = ST_MXH;
            ST_MXH:
            begin
                acc_next   = 64'(prod_reg) - bias;
                state_next = ST_MZL;
            end
            ST_MZL:
            begin
                cx_next    = 33'($signed(pos_v[63:32]));
                tx_next    = pos_v[31:16];
                state_next = ST_MZH;
            end
            ST_MZH:
            begin
                acc_next   = 64'(prod_reg) - bias;
                state_next = ST_MZF;
            end
            ST_MZF:
            begin
                cz_next    = 33'($signed(pos_v[63:32]));
                tz_next    = pos_v[31:16];
                state_next = (item_reg.op == OP_SAMPLE) ? ST_S0 : ST_IDX;
            end
            ST_IDX:
            begin
                ram_raddr = cell_addr(cx_reg[XW-1:0], cz_reg[ZW-1:0]);
                if (item_reg.op == OP_WRITE_IDX || item_reg.op == OP_WRITE_COORD)
                begin
                    ram_we     = ing;
                    ok_next    = ing;
                    state_next = ST_DONE;
                end
                else if (ing)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_IDXD;
                end
                else
                begin
                    // outside the grid: reads give the fill-in value, adds fail
                    res_next   = (item_reg.op == OP_ADD_IDX) ? 32'sd0 : oob_reg;
                    state_next = ST_DONE;
                end
            end
            ST_IDXD:
            begin
                if (item_reg.op == OP_ADD_IDX)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = sat32(66'($signed(ram_rdata)) + 66'(item_reg.value));
                    ok_next   = 1'b1;
                end
                else
                begin
                    res_next = ram_rdata;
                end
                state_next = ST_DONE;
            end
            ST_S0, ST_S1, ST_S2, ST_S3:
            begin
                ram_re       = ing;
                prev_in_next = ing;
                unique case (state_reg)
                    ST_S0:   state_next = ST_S1;
                    ST_S1:   begin c_next = corner_v; state_next = ST_S2; end
                    ST_S2:   begin d_next = corner_v; state_next = ST_S3; end
                    default: begin a_next = corner_v; state_next = ST_S4; end
                endcase
            end
            ST_S4:
            begin
                b_next     = corner_v;
                state_next = ST_S5;
            end
            ST_S5:
            begin
                l1_next    = lerp_fin(c_reg, prod_reg);
                state_next = ST_S6;
            end
            ST_S6:
            begin
                l2_next    = lerp_fin(a_reg, prod_reg);
                state_next = ST_S7;
            end
            ST_S7: state_next = ST_S8;
            ST_S8:
            begin
                res_next   = lerp_fin(l1_reg, prod_reg);
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // x outer, z inner
                ram_re    = 1'b1;
                ram_raddr = cell_addr(sx_reg, sz_reg);
                pv_next   = 1'b1;
                dx_next   = sx_reg;
                dz_next   = sz_reg;
                if (last_cell)
                begin
                    state_next = ST_SCANE;
                end
                else if (sz_reg == ZW'(GRID_H - 1))
                begin
                    sz_next = '0;
                    sx_next = sx_reg + XW'(1);
                end
                else
                begin
                    sz_next = sz_reg + ZW'(1);
                end
            end
            ST_SCANE:
            begin
                if (is_max && item_reg.op == OP_MAX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    fx_next    = '0;
                    fz_next    = '0;
                    state_next = ST_DONE;
                end
            end
            ST_FILL, ST_SC3:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(sx_reg, sz_reg);
                if (state_reg == ST_SC3)
                begin
                    ram_wdata = sat32(scale_v);
                end
                if (last_cell)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = (state_reg == ST_SC3) ? ST_SC0 : ST_FILL;
                    if (sz_reg == ZW'(GRID_H - 1))
                    begin
                        sz_next = '0;
                        sx_next = sx_reg + XW'(1);
                    end
                    else
                    begin
                        sz_next = sz_reg + ZW'(1);
                    end
                end
            end
            ST_SC0:
            begin
                ram_re     = 1'b1;
                ram_raddr  = cell_addr(sx_reg, sz_reg);
                state_next = ST_SC1;
            end
            ST_SC1:
            begin
                cell_next  = ram_rdata;
                state_next = ST_SC2;
            end
            ST_SC2:
            begin
                acc_next   = 64'(prod_reg);
                state_next = ST_SC3;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    out_next.result_value = res_reg;
                    out_next.ok           = ok_reg;
                    out_next.found_x      = fx_reg;
                    out_next.found_z      = fz_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            first_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pv_reg        <= pv_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        item_reg    <= item_next;
        res_reg     <= res_next;
        ok_reg      <= ok_next;
        fx_reg      <= fx_next;
        fz_reg      <= fz_next;
        cx_reg      <= cx_next;
        cz_reg      <= cz_next;
        tx_reg      <= tx_next;
        tz_reg      <= tz_next;
        acc_reg     <= acc_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        l1_reg      <= l1_next;
        l2_reg      <= l2_next;
        cell_reg    <= cell_next;
        prev_in_reg <= prev_in_next;
        sx_reg      <= sx_next;
        sz_reg      <= sz_next;
        dx_reg      <= dx_next;
        dz_reg      <= dz_next;
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for grid_store_bilinear_sampler: directed and random words,
// predicted results checked field by field, APB register phases, stalls on both sides.
// Depends on gsbs_pkg and the grid_store_bilinear_sampler RTL.
module tb_top;
    import gsbs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_store_bilinear_sampler DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int WATCHDOG_LIMIT = 4 * (4 * DEPTH + 200) + 2000;

    // Shadow state of the block
    logic signed [31:0] cell_mem [DEPTH];
    logic signed [31:0] org_x, org_z, oob_val;
    logic [30:0]        inv_x, inv_z;

    out_word_t   expected_q[$];
    int          error_count;
    int          words_sent;
    int          results_seen;
    int          idle_cycles;
    bit          timed_out;
    bit          hold_recv;
    bit          calm;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic signed [63:0] floor_div(input logic signed [63:0] v, input int k);
        return v >>> k;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bit on_grid(input logic signed [63:0] x, input logic signed [63:0] z);
        return x >= 0 && x < GRID_W && z >= 0 && z < GRID_H;
    endfunction

    function automatic logic signed [63:0] cell_at(input logic signed [63:0] x,
                                                   input logic signed [63:0] z);
        if (!on_grid(x, z))
            return 64'(oob_val);
        return 64'(cell_mem[x + z * GRID_W]);
    endfunction

    function automatic logic signed [63:0] blend(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input logic signed [63:0] t);
        return floor_div(a * (65536 - t) + b * t + 32768, 16);
    endfunction

    // Compute the result of one word and update the shadow grid
    function automatic out_word_t grid_predict(input in_word_t w);
        out_word_t r;
        logic signed [63:0] px, pz, ix, iz, tx, tz, v, best;
        logic signed [63:0] xi, zi;
        bit first;
        r = '0;
        xi = 64'(w.x_index);
        zi = 64'(w.z_index);
        px = (64'(w.coord_x) - 64'(org_x)) * $signed({33'd0, inv_x});
        pz = (64'(w.coord_z) - 64'(org_z)) * $signed({33'd0, inv_z});
        case (w.op)
            OP_READ_IDX:
                r.result_value = cell_at(xi, zi);
            OP_WRITE_IDX:
                if (on_grid(xi, zi))
                begin
                    cell_mem[xi + zi * GRID_W] = w.value;
                    r.ok = 1'b1;
                end
            OP_ADD_IDX:
                if (on_grid(xi, zi))
                begin
                    cell_mem[xi + zi * GRID_W] =
                        clamp32(64'(cell_mem[xi + zi * GRID_W]) + 64'(w.value));
                    r.ok = 1'b1;
                end
            OP_READ_COORD, OP_WRITE_COORD:
            begin
                ix = floor_div(px, 32);
                iz = floor_div(pz, 32);
                if (w.op == OP_READ_COORD)
                    r.result_value = cell_at(ix, iz);
                else if (on_grid(ix, iz))
                begin
                    cell_mem[ix + iz * GRID_W] = w.value;
                    r.ok = 1'b1;
                end
            end
            OP_SAMPLE:
            begin
                px = px - 64'sd2147483648;
                pz = pz - 64'sd2147483648;
                ix = floor_div(px, 32);
                iz = floor_div(pz, 32);
                tx = {48'd0, px[31:16]};
                tz = {48'd0, pz[31:16]};
                r.result_value = blend(blend(cell_at(ix, iz), cell_at(ix + 1, iz), tx),
                                       blend(cell_at(ix, iz + 1), cell_at(ix + 1, iz + 1), tx),
                                       tz);
            end
            OP_MAX, OP_MIN, OP_MAXABS:
            begin
                first = 1'b1;
                best = 0;
                for (int x = 0; x < GRID_W; x++)
                    for (int z = 0; z < GRID_H; z++)
                    begin
                        v = 64'(cell_mem[x + z * GRID_W]);
                        if (w.op == OP_MAXABS)
                            v = clamp32(v < 0 ? -v : v);
                        if (first || (w.op == OP_MIN ? v < best : v > best))
                        begin
                            best = v;
                            r.found_x = x[5:0];
                            r.found_z = z[5:0];
                            first = 1'b0;
                        end
                    end
                r.result_value = best[31:0];
                if (w.op != OP_MAX)
                begin
                    r.found_x = '0;
                    r.found_z = '0;
                end
            end
            OP_FILL:
                for (int i = 0; i < DEPTH; i++)
                    cell_mem[i] = w.value;
            OP_SCALE:
                for (int i = 0; i < DEPTH; i++)
                    cell_mem[i] = clamp32(floor_div(64'(cell_mem[i]) * 64'(w.value) + 32768,
                                                    16));
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Drive one word and wait until it is taken; valid stays up until the next word
    task automatic send_word(input in_word_t w);
        while (!calm && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        expected_q.push_back(grid_predict(w));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIGIN_X: org_x = data;
            REG_ORIGIN_Z: org_z = data;
            REG_INV_X:    inv_x = data[30:0];
            REG_INV_Z:    inv_z = data[30:0];
            REG_OOB:      oob_val = data;
            default:      ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && !timed_out)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
    endtask

    function automatic in_word_t make_word(input logic [3:0] op, input int xi, input int zi,
                                           input logic [31:0] cx, input logic [31:0] cz,
                                           input logic [31:0] val);
        in_word_t w;
        w.op = op;
        w.x_index = xi[15:0];
        w.z_index = zi[15:0];
        w.coord_x = cx;
        w.coord_z = cz;
        w.value = val;
        return w;
    endfunction

    function automatic logic [31:0] rand32;
        return $urandom;
    endfunction

    // Equal shares of full-range, near-maximum, near-minimum and small-magnitude values
    function automatic logic [31:0] pick_value;
        case ($urandom_range(3))
            0: return rand32();
            1: return 32'h7FFFFFFF - $urandom_range(3);
            2: return 32'h80000000 + $urandom_range(3);
            default: return $signed($urandom_range(400000)) - 200000;
        endcase
    endfunction

    function automatic int pick_index;
        if ($urandom_range(9) == 0)
            return $signed(16'($urandom));
        return $signed($urandom_range(GRID_W + 1)) - 1;
    endfunction

    function automatic logic [31:0] pick_coord(input logic signed [31:0] org);
        if ($urandom_range(9) == 0)
            return rand32();
        return org + ($signed($urandom_range(GRID_W * 65536 + 131072)) - 65536);
    endfunction

    task automatic test_directed;
        send_word(make_word(OP_FILL, 0, 0, 0, 0, 32'h00010000));
        send_word(make_word(OP_READ_IDX, 0, 0, 0, 0, 0));
        send_word(make_word(OP_WRITE_IDX, 63, 63, 0, 0, 32'h7FFFFFFF));
        send_word(make_word(OP_ADD_IDX, 63, 63, 0, 0, 32'h7FFFFFFF));
        send_word(make_word(OP_WRITE_IDX, 0, 5, 0, 0, 32'h80000000));
        send_word(make_word(OP_ADD_IDX, 0, 5, 0, 0, 32'h80000000));
        send_word(make_word(OP_WRITE_IDX, -32768, 32767, 0, 0, 1));
        send_word(make_word(OP_ADD_IDX, 64, 0, 0, 0, 1));
        send_word(make_word(OP_READ_IDX, -1, 0, 0, 0, 0));
        send_word(make_word(OP_READ_IDX, 63, 63, 0, 0, 0));
        send_word(make_word(OP_MAX, 0, 0, 0, 0, 0));
        send_word(make_word(OP_MIN, 0, 0, 0, 0, 0));
        send_word(make_word(OP_MAXABS, 0, 0, 0, 0, 0));
        send_word(make_word(OP_WRITE_COORD, 0, 0, 32'h00028000, 32'h0003FFFF, 32'h1234));
        send_word(make_word(OP_READ_COORD, 0, 0, 32'hFFFFFFFF, 32'h00000000, 0));
        send_word(make_word(OP_READ_COORD, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0));
        send_word(make_word(OP_SAMPLE, 0, 0, 32'h00008000, 32'h00008000, 0));
        send_word(make_word(OP_SAMPLE, 0, 0, 32'h00000000, 32'h00000000, 0));
        send_word(make_word(OP_SAMPLE, 0, 0, 32'h003FC000, 32'h003F8000, 0));
        send_word(make_word(OP_SCALE, 0, 0, 0, 0, 32'hFFFF8000));
        send_word(make_word(OP_MAX, 0, 0, 0, 0, 0));
        send_word(make_word(OP_SCALE, 0, 0, 0, 0, 32'h7FFFFFFF));
        send_word(make_word(OP_MAXABS, 0, 0, 0, 0, 0));
        send_word(make_word(4'd11, 0, 0, 0, 0, 0));
        send_word(make_word(4'd15, -1, -1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        drain();
    endtask

    // Random traffic, unused op codes included; grid stays fully written since fill opened the run
    task automatic test_random(input int count);
        in_word_t w;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(999);
            if (r < 4)
                w = make_word(OP_SCALE, 0, 0, 0, 0, $urandom_range(131072));
            else if (r < 8)
                w = make_word(OP_FILL, 0, 0, 0, 0, pick_value());
            else if (r < 30)
                w = make_word(4'($urandom_range(OP_MAX, OP_MAXABS)), 0, 0, 0, 0, 0);
            else if (r < 40)
                w = make_word(4'($urandom_range(11, 15)), pick_index(), pick_index(),
                              rand32(), rand32(), rand32());
            else
            begin
                w = make_word(4'($urandom_range(OP_READ_IDX, OP_SAMPLE)), pick_index(),
                              pick_index(), pick_coord(org_x), pick_coord(org_z),
                              pick_value());
                if ($urandom_range(7) == 0)
                    w.coord_x = rand32();
            end
            send_word(w);
        end
        drain();
    endtask

    task automatic test_registers;
        apb_write(REG_ORIGIN_X, 32'h80000000);
        apb_write(REG_ORIGIN_Z, 32'h7FFFFFFF);
        apb_write(REG_INV_X, 32'h7FFFFFFF);
        apb_write(REG_INV_Z, 32'd1);
        apb_write(REG_OOB, 32'h80000000);
        test_random(60);
        apb_write(REG_ORIGIN_X, 32'hFFF00000);
        apb_write(REG_ORIGIN_Z, 32'h00030000);
        apb_write(REG_INV_X, 32'h00020000);
        apb_write(REG_INV_Z, 32'h00008000);
        apb_write(REG_OOB, 32'h7FFFFFFF);
        test_random(250);
        apb_write(REG_INV_X, 32'd0);
        apb_write(REG_INV_Z, 32'h00010000);
        test_random(40);
        apb_write(REG_ORIGIN_X, 32'd0);
        apb_write(REG_ORIGIN_Z, 32'd0);
        apb_write(REG_INV_X, 32'h00010000);
        apb_write(REG_OOB, rand32());
    endtask

    // Receiver holds off while the sender keeps offering words
    task automatic test_backpressure;
        hold_recv = 1'b1;
        fork
            begin
                repeat (300)
                    @(negedge clk);
                hold_recv = 1'b0;
            end
            test_random(30);
        join
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || hold_recv)
            out_stall <= 1'b1;
        else
            out_stall <= !calm && ($urandom_range(99) < 14);
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("MISMATCH: result %h with nothing expected", out_word);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_word.result_value !== want.result_value)
                    report_mismatch("result_value", out_word.result_value,
                                    want.result_value);
                if (out_word.ok !== want.ok)
                    report_mismatch("ok", 32'(out_word.ok), 32'(want.ok));
                if (out_word.found_x !== want.found_x)
                    report_mismatch("found_x", 32'(out_word.found_x), 32'(want.found_x));
                if (out_word.found_z !== want.found_z)
                    report_mismatch("found_z", 32'(out_word.found_z), 32'(want.found_z));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Watchdog: no progress for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_recv = 1'b0;
        calm = 1'b0;
        timed_out = 1'b0;
        error_count = 0;
        words_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        org_x = 0;
        org_z = 0;
        inv_x = 31'd65536;
        inv_z = 31'd65536;
        oob_val = 0;
        for (int i = 0; i < DEPTH; i++)
            cell_mem[i] = 0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_registers();
        test_backpressure();
        calm = 1'b1;
        test_random(150);
        calm = 1'b0;
        test_random(450);
        $display("Covered %0d words, %0d results: index/coord access, sampling, scans,",
                 words_sent, results_seen);
        $display("fill and scale under several register settings with stalls on both sides");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gsbs_pkg.sv
rtl/core/gsbs_ram.sv
rtl/core/grid_store_bilinear_sampler.sv
tb/tb_top.sv
